@@ design/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// Sparse-set identifier table package
// Widths, limits, codes and shared types of the identifier table.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int unsigned MaxId       = 1023;
  localparam int unsigned Capacity    = 256;
  localparam int unsigned IdW         = 10;
  localparam int unsigned IdxW        = 8;
  localparam int unsigned CntW        = 9;
  localparam int unsigned TagW        = 32;
  localparam int unsigned SparseDepth = MaxId + 1;

  localparam logic [CntW-1:0] EmptySlot   = CntW'(Capacity);
  localparam logic [CntW-1:0] CapacityCnt = CntW'(Capacity);
  localparam logic [IdW-1:0]  MaxIdVal    = IdW'(MaxId);

  typedef enum logic [1:0] {
    OpAdd    = 2'd0,
    OpDelete = 2'd1,
    OpFind   = 2'd2,
    OpClear  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StIdle  = 2'd0,
    StLook  = 2'd1,
    StCheck = 2'd2,
    StErase = 2'd3
  } state_e;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [TagW-1:0] tag;
  } dense_entry_t;

  typedef struct packed {
    logic            we;
    logic [IdW-1:0]  waddr;
    logic [CntW-1:0] wdata;
    logic [IdW-1:0]  raddr;
  } sparse_req_t;

  typedef struct packed {
    logic         we;
    logic [IdxW-1:0] waddr;
    dense_entry_t wdata;
    logic [IdxW-1:0] raddr_a;
    logic [IdxW-1:0] raddr_b;
  } dense_req_t;

endpackage

@@ design/sst_sparse_ram.sv @@
// ----------------------------------------------------------------------------
// Sparse array memory
// Slot number of every identifier, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module sst_sparse_ram (
  input  logic                       clk_i,
  input  sst_pkg::sparse_req_t       req_i,
  output logic [sst_pkg::CntW-1:0]   rdata_o
);

  logic [sst_pkg::CntW-1:0] mem [sst_pkg::SparseDepth];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule

@@ design/sst_dense_ram.sv @@
// ----------------------------------------------------------------------------
// Dense array memory
// Identifier and tag of every slot, one write and two registered reads a cycle.
// ----------------------------------------------------------------------------
module sst_dense_ram (
  input  logic                  clk_i,
  input  sst_pkg::dense_req_t   req_i,
  output sst_pkg::dense_entry_t rdata_a_o,
  output sst_pkg::dense_entry_t rdata_b_o
);

  sst_pkg::dense_entry_t mem [sst_pkg::Capacity];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_a_o <= mem[req_i.raddr_a];
    rdata_b_o <= mem[req_i.raddr_b];
  end

endmodule

@@ design/sparse_set_id_table_core.sv @@
// Add and clear keep the core idle: the next beat is accepted once the output is free.
// Find runs the lookup and check states and a delete that hits adds the erase state,
// set by the sparse read, dense read and single write port of the sparse memory.
// Reset clears the count and identifier counter and restores the full capacity at once.
// No clearing pass: sparse entries above the last issued identifier never count as live.
// ----------------------------------------------------------------------------
// Sparse-set identifier table
// Hands out identifiers, stores tags in dense slots, finds and deletes entries.
// ----------------------------------------------------------------------------
module sparse_set_id_table_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 operation_i,
  input  logic [sst_pkg::IdW-1:0]    entry_id_i,
  input  logic [sst_pkg::TagW-1:0]   entry_tag_i,
  input  logic                       cfg_we_i,
  input  logic [sst_pkg::CntW-1:0]   cfg_wdata_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       ok_o,
  output logic [sst_pkg::IdW-1:0]    result_id_o,
  output logic [sst_pkg::IdxW-1:0]   slot_index_o,
  output logic [sst_pkg::TagW-1:0]   found_tag_o,
  output logic [sst_pkg::CntW-1:0]   entry_count_o
);

  sst_pkg::state_e state_q, state_d;
  sst_pkg::op_e    op_q, op_in;
  logic [sst_pkg::IdW-1:0]  id_q;
  logic [sst_pkg::CntW-1:0] slot_q;
  logic [sst_pkg::CntW-1:0] live_q, live_d;
  logic [sst_pkg::IdW-1:0]  last_id_q, last_id_d;
  logic [sst_pkg::CntW-1:0] cap_q;

  logic                      out_valid_q;
  logic                      ok_q, ok_d;
  logic [sst_pkg::IdW-1:0]   rid_q, rid_d;
  logic [sst_pkg::IdxW-1:0]  slot_out_q, slot_out_d;
  logic [sst_pkg::TagW-1:0]  tag_q, tag_d;
  logic [sst_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic                      load;

  sst_pkg::sparse_req_t      sparse_req;
  sst_pkg::dense_req_t       dense_req;
  logic [sst_pkg::CntW-1:0]  sparse_rdata;
  sst_pkg::dense_entry_t     dense_a, dense_b;

  logic out_free, in_acc, add_ok, hit;
  logic [sst_pkg::IdW-1:0]  next_id;
  logic [sst_pkg::IdxW-1:0] last_slot;

  sst_sparse_ram u_sparse (
    .clk_i   (clk_i),
    .req_i   (sparse_req),
    .rdata_o (sparse_rdata)
  );

  sst_dense_ram u_dense (
    .clk_i     (clk_i),
    .req_i     (dense_req),
    .rdata_a_o (dense_a),
    .rdata_b_o (dense_b)
  );

  assign op_in      = sst_pkg::op_e'(operation_i);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != sst_pkg::StIdle) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign next_id    = last_id_q + sst_pkg::IdW'(1);
  assign last_slot  = sst_pkg::IdxW'(live_q - sst_pkg::CntW'(1));
  assign add_ok     = (live_q < cap_q) && (live_q < sst_pkg::CapacityCnt) &&
                      (last_id_q < sst_pkg::MaxIdVal);

  // An identifier is live when issued, its slot is below the count and the slot holds it.
  assign hit = (id_q != '0) && (id_q <= sst_pkg::MaxIdVal) && (id_q <= last_id_q) &&
               (slot_q < live_q) && (dense_a.id == id_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      sst_pkg::StIdle: begin
        if (in_acc && (op_in == sst_pkg::OpDelete || op_in == sst_pkg::OpFind)) begin
          state_d = sst_pkg::StLook;
        end
      end
      sst_pkg::StLook: begin
        state_d = sst_pkg::StCheck;
      end
      sst_pkg::StCheck: begin
        if (op_q == sst_pkg::OpDelete && hit) begin
          state_d = sst_pkg::StErase;
        end else if (out_free) begin
          state_d = sst_pkg::StIdle;
        end
      end
      sst_pkg::StErase: begin
        if (out_free) begin
          state_d = sst_pkg::StIdle;
        end
      end
      default: begin
        state_d = sst_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    live_d            = live_q;
    last_id_d         = last_id_q;
    load              = 1'b0;
    ok_d              = 1'b0;
    rid_d             = '0;
    slot_out_d        = '0;
    tag_d             = '0;
    cnt_d             = live_q;
    sparse_req.we     = 1'b0;
    sparse_req.waddr  = next_id;
    sparse_req.wdata  = live_q;
    sparse_req.raddr  = (state_q == sst_pkg::StIdle) ? entry_id_i : id_q;
    dense_req.we      = 1'b0;
    dense_req.waddr   = live_q[sst_pkg::IdxW-1:0];
    dense_req.wdata   = '{id: next_id, tag: entry_tag_i};
    dense_req.raddr_a = (state_q == sst_pkg::StLook) ? sparse_rdata[sst_pkg::IdxW-1:0]
                                                     : slot_q[sst_pkg::IdxW-1:0];
    dense_req.raddr_b = last_slot;
    case (state_q)
      sst_pkg::StIdle: begin
        if (in_acc && op_in == sst_pkg::OpAdd) begin
          load = 1'b1;
          if (add_ok) begin
            sparse_req.we = 1'b1;
            dense_req.we  = 1'b1;
            last_id_d     = next_id;
            live_d        = live_q + sst_pkg::CntW'(1);
            ok_d          = 1'b1;
            rid_d         = next_id;
            slot_out_d    = live_q[sst_pkg::IdxW-1:0];
          end
          cnt_d = live_d;
        end else if (in_acc && op_in == sst_pkg::OpClear) begin
          load   = 1'b1;
          live_d = '0;
          ok_d   = 1'b1;
          cnt_d  = '0;
        end
      end
      sst_pkg::StCheck: begin
        if (op_q == sst_pkg::OpDelete && hit) begin
          // Move the last slot into the freed one and repoint its identifier.
          dense_req.we     = 1'b1;
          dense_req.waddr  = slot_q[sst_pkg::IdxW-1:0];
          dense_req.wdata  = dense_b;
          sparse_req.we    = (dense_b.id <= sst_pkg::MaxIdVal);
          sparse_req.waddr = dense_b.id;
          sparse_req.wdata = slot_q;
        end else if (out_free) begin
          load = 1'b1;
          if (op_q == sst_pkg::OpFind && hit) begin
            ok_d       = 1'b1;
            rid_d      = id_q;
            slot_out_d = slot_q[sst_pkg::IdxW-1:0];
            tag_d      = dense_a.tag;
          end
        end
      end
      sst_pkg::StErase: begin
        sparse_req.we    = 1'b1;
        sparse_req.waddr = id_q;
        sparse_req.wdata = sst_pkg::EmptySlot;
        if (out_free) begin
          load   = 1'b1;
          live_d = live_q - sst_pkg::CntW'(1);
          ok_d   = 1'b1;
          cnt_d  = live_d;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sst_pkg::StIdle;
      live_q      <= '0;
      last_id_q   <= '0;
      cap_q       <= sst_pkg::CapacityCnt;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      live_q    <= live_d;
      last_id_q <= last_id_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= op_in;
      id_q <= entry_id_i;
    end
    if (state_q == sst_pkg::StLook) begin
      slot_q <= sparse_rdata;
    end
    if (load) begin
      ok_q       <= ok_d;
      rid_q      <= rid_d;
      slot_out_q <= slot_out_d;
      tag_q      <= tag_d;
      cnt_q      <= cnt_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_q;
  assign result_id_o   = rid_q;
  assign slot_index_o  = slot_out_q;
  assign found_tag_o   = tag_q;
  assign entry_count_o = cnt_q;

`ifndef SYNTHESIS
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= sst_pkg::CapacityCnt)
    else $error("Entry count exceeds the table capacity.");

  a_erase_is_delete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sst_pkg::StErase) |-> (op_q == sst_pkg::OpDelete))
    else $error("Erase state entered by an operation other than delete.");

  a_erase_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sst_pkg::StErase && out_free) |=>
      (entry_count_o == $past(live_q) - sst_pkg::CntW'(1)) && out_valid_o)
    else $error("Delete beat does not report the reduced entry count.");

  a_lookup_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (op_in == sst_pkg::OpFind || op_in == sst_pkg::OpDelete)) |=>
      (state_q == sst_pkg::StLook))
    else $error("Find or delete did not start the sparse lookup.");
`endif

endmodule
